/* design/nnue_pkg.sv */
package nnue_pkg;

    typedef enum logic [1:0] {
        FUNC_ADD,
        FUNC_SUB,
        FUNC_ADDSUB,
        FUNC_DOT
    } t_func;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SQUARE,
        S_MULT,
        S_ACCUM
    } t_state;

    localparam int unsigned VALUE_W  = 16;
    localparam int unsigned INDEX_W  = 11;
    localparam int unsigned CLAMP_W  = 15;
    localparam int unsigned SUM_W    = 32;
    localparam int unsigned SQUARE_W = 2 * CLAMP_W;
    localparam logic [CLAMP_W-1:0] CLAMP_RESET = 15'd255;

endpackage

/* design/nnue_accumulator_screlu_engine_top.sv */
// accumulator engine with squared clipped relu dot product
// usage:
//   - an item is taken when start is high and busy is low; its fields are
//     i_func, i_element_index, i_add_value, i_sub_value, i_out_weight, i_last
//   - add, subtract and add-subtract items update one element of the int16
//     accumulator memory in place; dot items clamp the stored element to
//     0..clamp, square it, multiply by i_out_weight and add into a 32-bit sum
//   - user writes clamp bound (i_clamp_we/i_clamp_high) while idle; unenforced
//   - on an item with i_last set, o_result_valid pulses for one cycle with
//     o_dot_sum (zero for update items) and o_done_func; the running sum clears
// timing:
//   - update items: memory read, then modify and write back
//   - dot items step through memory read, clamp, square, weight multiply and
//     sum, along the registered multiplier chain
//   - the result strobe comes in the cycle after the item's last step
// reset:
//   - after reset the engine clears the accumulator memory, one element per
//     cycle, over all ACC_LENGTH elements with busy high; clamp resets to 255
//   - the receiver cannot stall: each result is shown for exactly one cycle
module nnue_accumulator_screlu_engine_top #(
    parameter int unsigned ACC_LENGTH = 1536
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       start,
    output logic                                       busy,
    input  nnue_pkg::t_func                            i_func,
    input  logic [nnue_pkg::INDEX_W-1:0]               i_element_index,
    input  logic signed [nnue_pkg::VALUE_W-1:0]        i_add_value,
    input  logic signed [nnue_pkg::VALUE_W-1:0]        i_sub_value,
    input  logic signed [nnue_pkg::SUM_W-1:0]          i_out_weight,
    input  logic                                       i_last,
    input  logic                                       i_clamp_we,
    input  logic [nnue_pkg::CLAMP_W-1:0]               i_clamp_high,
    output logic                                       o_result_valid,
    output logic signed [nnue_pkg::SUM_W-1:0]          o_dot_sum,
    output nnue_pkg::t_func                            o_done_func
);

    import nnue_pkg::*;

    localparam int unsigned AW = $clog2(ACC_LENGTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(ACC_LENGTH - 1);

    t_state                r_state, n_state;
    logic [AW-1:0]         r_clr_cnt, n_clr_cnt;
    t_func                 r_func;
    logic [AW-1:0]         r_addr;
    logic                  r_idx_ok;
    logic [VALUE_W-1:0]    r_add, r_sub;
    logic [SUM_W-1:0]      r_weight;
    logic                  r_last;
    logic [CLAMP_W-1:0]    r_act, n_act;
    logic [SQUARE_W-1:0]   r_sq;
    logic [SUM_W-1:0]      r_prod;
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic [CLAMP_W-1:0]    r_clamp;
    logic                  r_res_valid, n_res_valid;
    logic [SUM_W-1:0]      r_dot_sum, n_dot_sum;
    t_func                 r_done_func, n_done_func;

    logic                  w_accept;
    logic                  w_idx_ok;
    logic [AW-1:0]         w_idx_addr;
    logic                  w_ram_we;
    logic [AW-1:0]         w_ram_addr;
    logic [VALUE_W-1:0]    w_ram_wdata;
    logic [VALUE_W-1:0]    w_ram_rdata;
    logic [VALUE_W-1:0]    w_elem;
    logic [SUM_W-1:0]      w_total;

    assign busy       = (r_state != S_IDLE);
    assign w_accept   = start && !busy;
    assign w_idx_ok   = (32'(i_element_index) < 32'(ACC_LENGTH));
    assign w_idx_addr = AW'(32'(i_element_index));

    nnue_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (ACC_LENGTH)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = (r_func == FUNC_DOT) ? S_SQUARE : S_IDLE;
            end
            S_SQUARE: n_state = S_MULT;
            S_MULT:   n_state = S_ACCUM;
            S_ACCUM:  n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_clr_cnt   = r_clr_cnt;
        n_act       = r_act;
        n_sum       = r_sum;
        n_res_valid = 1'b0;
        n_dot_sum   = r_dot_sum;
        n_done_func = r_done_func;
        w_ram_we    = 1'b0;
        w_ram_addr  = r_addr;
        w_ram_wdata = '0;
        w_elem      = r_idx_ok ? w_ram_rdata : '0;
        w_total     = r_sum + r_prod;
        case (r_state)
            S_CLEAR: begin
                w_ram_we   = 1'b1;
                w_ram_addr = r_clr_cnt;
                n_clr_cnt  = r_clr_cnt + 1'b1;
            end
            S_IDLE: begin
                w_ram_addr = w_idx_addr;
            end
            S_READ: begin
                if (r_func == FUNC_DOT) begin
                    if (w_elem[VALUE_W-1]) begin
                        n_act = '0;
                    end else if (w_elem[CLAMP_W-1:0] > r_clamp) begin
                        n_act = r_clamp;
                    end else begin
                        n_act = w_elem[CLAMP_W-1:0];
                    end
                end else begin
                    case (r_func)
                        FUNC_ADD: w_ram_wdata = w_ram_rdata + r_add;
                        FUNC_SUB: w_ram_wdata = w_ram_rdata - r_sub;
                        default:  w_ram_wdata = w_ram_rdata + r_add - r_sub;
                    endcase
                    w_ram_we = r_idx_ok;
                    if (r_last) begin
                        n_res_valid = 1'b1;
                        n_dot_sum   = '0;
                        n_done_func = r_func;
                        n_sum       = '0;
                    end
                end
            end
            S_ACCUM: begin
                if (r_last) begin
                    n_res_valid = 1'b1;
                    n_dot_sum   = w_total;
                    n_done_func = r_func;
                    n_sum       = '0;
                end else begin
                    n_sum = w_total;
                end
            end
            default: begin
                w_ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_sum       <= '0;
            r_clamp     <= CLAMP_RESET;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_sum       <= n_sum;
            r_res_valid <= n_res_valid;
            if (i_clamp_we) begin
                r_clamp <= i_clamp_high;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func   <= i_func;
            r_addr   <= w_idx_addr;
            r_idx_ok <= w_idx_ok;
            r_add    <= i_add_value;
            r_sub    <= i_sub_value;
            r_weight <= i_out_weight;
            r_last   <= i_last;
        end
        r_act       <= n_act;
        r_sq        <= r_act * r_act;
        r_prod      <= SUM_W'(r_sq) * r_weight;
        r_dot_sum   <= n_dot_sum;
        r_done_func <= n_done_func;
    end

    assign o_result_valid = r_res_valid;
    assign o_dot_sum      = r_dot_sum;
    assign o_done_func    = r_done_func;

    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (r_state == S_IDLE))
        else $error("result strobe while an item is in flight");

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_result_valid)
        else $error("result strobe during memory clear");

    a_update_sum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_done_func != FUNC_DOT)) |-> (o_dot_sum == '0))
        else $error("update sweep result carries a nonzero sum");

    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ram_we && (r_state != S_CLEAR)) |-> ((r_state == S_READ) && (r_func != FUNC_DOT)))
        else $error("memory write outside an update item");

    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (r_sum == '0))
        else $error("running sum not cleared after result");

endmodule

/* design/nnue_ram.sv */
module nnue_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sim/nnue_accumulator_screlu_engine_top_test.sv */
module nnue_accumulator_screlu_engine_top_test;
    import nnue_pkg::*;

    localparam int ACC_LENGTH = 1536;

    typedef struct packed {
        t_func       func;
        logic [10:0] idx;
        logic [15:0] addv;
        logic [15:0] subv;
        logic [31:0] wgt;
        logic        last;
        logic        typed;
        logic [31:0] exp_sum;
    } t_stim_row;

    typedef struct packed {
        logic [31:0] dot_sum;
        t_func       func;
    } t_sweep_result;

    // hand-checked sum only where the typed flag is set, clamp at its reset value
    localparam t_stim_row DIRECTED_ROWS [20] = '{
        '{FUNC_DOT,    11'd0,    16'h0000, 16'h0000, 32'd1,         1'b1, 1'b1, 32'd0},
        '{FUNC_ADD,    11'd0,    16'h7FFF, 16'h0000, 32'd0,         1'b0, 1'b0, 32'd0},
        '{FUNC_DOT,    11'd0,    16'h0000, 16'h0000, 32'd1,         1'b1, 1'b1, 32'd65025},
        '{FUNC_SUB,    11'd1,    16'h0000, 16'h8000, 32'd0,         1'b0, 1'b0, 32'd0},
        '{FUNC_DOT,    11'd1,    16'h0000, 16'h0000, 32'd7,         1'b1, 1'b1, 32'd0},
        '{FUNC_ADDSUB, 11'd1535, 16'd100,  16'hFFCE, 32'd0,         1'b0, 1'b0, 32'd0},
        '{FUNC_DOT,    11'd1535, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_A81C},
        '{FUNC_ADD,    11'd1536, 16'd5,    16'h0000, 32'd0,         1'b0, 1'b0, 32'd0},
        '{FUNC_ADD,    11'd2047, 16'hFFFF, 16'h0000, 32'd0,         1'b1, 1'b1, 32'd0},
        '{FUNC_DOT,    11'd1536, 16'h0000, 16'h0000, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'd0},
        '{FUNC_DOT,    11'd0,    16'h0000, 16'h0000, 32'h8000_0000, 1'b0, 1'b0, 32'd0},
        '{FUNC_DOT,    11'd0,    16'hFFFF, 16'hFFFF, 32'h8000_0000, 1'b1, 1'b1, 32'd0},
        '{FUNC_SUB,    11'd2,    16'h0000, 16'h7FFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0},
        '{FUNC_ADDSUB, 11'd2,    16'h8000, 16'h7FFF, 32'd0,         1'b1, 1'b1, 32'd0},
        '{FUNC_SUB,    11'd3,    16'h0000, 16'd1,    32'd0,         1'b1, 1'b1, 32'd0},
        '{FUNC_DOT,    11'd0,    16'h0000, 16'h0000, 32'd2,         1'b0, 1'b0, 32'd0},
        '{FUNC_ADD,    11'd4,    16'd1,    16'h0000, 32'd0,         1'b1, 1'b1, 32'd0},
        '{FUNC_DOT,    11'd0,    16'h0000, 16'h0000, 32'd3,         1'b1, 1'b1, 32'd195075},
        '{FUNC_DOT,    11'd1535, 16'h0000, 16'h0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'd0},
        '{FUNC_DOT,    11'd1535, 16'h0000, 16'h0000, 32'd5,         1'b1, 1'b0, 32'd0}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    t_func               i_func = FUNC_ADD;
    logic [INDEX_W-1:0]  i_element_index = '0;
    logic [VALUE_W-1:0]  i_add_value = '0;
    logic [VALUE_W-1:0]  i_sub_value = '0;
    logic [SUM_W-1:0]    i_out_weight = '0;
    logic                i_last = 1'b0;
    logic                i_clamp_we = 1'b0;
    logic [CLAMP_W-1:0]  i_clamp_high = CLAMP_RESET;
    logic                o_result_valid;
    logic [SUM_W-1:0]    o_dot_sum;
    t_func               o_done_func;

    logic signed [15:0]  acc_image [ACC_LENGTH];
    logic [31:0]         dot_sum_image = '0;
    logic [14:0]         clamp_image = CLAMP_RESET;
    t_sweep_result       sweep_results_due [$];

    int items_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int clamp_writes = 0;

    nnue_accumulator_screlu_engine_top #(
        .ACC_LENGTH(ACC_LENGTH)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_func(i_func),
        .i_element_index(i_element_index),
        .i_add_value(i_add_value),
        .i_sub_value(i_sub_value),
        .i_out_weight(i_out_weight),
        .i_last(i_last),
        .i_clamp_we(i_clamp_we),
        .i_clamp_high(i_clamp_high),
        .o_result_valid(o_result_valid),
        .o_dot_sum(o_dot_sum),
        .o_done_func(o_done_func)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #(8 * 200000);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        foreach (acc_image[k]) acc_image[k] = '0;
    end

    function automatic bit accumulate_element(input t_func f, input logic [10:0] idx,
                                              input logic [15:0] addv, input logic [15:0] subv,
                                              input logic [31:0] wgt, input logic last,
                                              output t_sweep_result res);
        int          elem;
        logic [31:0] act;
        if (f == FUNC_DOT) begin
            elem = (idx < ACC_LENGTH) ? int'(acc_image[idx]) : 0;
            if (elem < 0) elem = 0;
            if (elem > int'(clamp_image)) elem = int'(clamp_image);
            act = 32'(elem);
            dot_sum_image = dot_sum_image + act * act * wgt;
        end else if (idx < ACC_LENGTH) begin
            case (f)
                FUNC_ADD: acc_image[idx] = acc_image[idx] + addv;
                FUNC_SUB: acc_image[idx] = acc_image[idx] - subv;
                default:  acc_image[idx] = acc_image[idx] + addv - subv;
            endcase
        end
        res.dot_sum = (f == FUNC_DOT) ? dot_sum_image : 32'd0;
        res.func = f;
        if (last) dot_sum_image = '0;
        return last;
    endfunction

    function automatic logic [10:0] pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 11'($urandom_range(0, 31));
        if (r < 88) return 11'($urandom_range(0, ACC_LENGTH - 1));
        return 11'($urandom_range(ACC_LENGTH, 2047));
    endfunction

    function automatic logic [15:0] pick_value();
        if ($urandom_range(0, 1) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 700) - 200);
    endfunction

    function automatic logic [31:0] pick_weight();
        if ($urandom_range(0, 1) == 0) return $urandom;
        return 32'($urandom_range(0, 16)) - 32'd8;
    endfunction

    task automatic send_item(input t_func f, input logic [10:0] idx, input logic [15:0] addv,
                             input logic [15:0] subv, input logic [31:0] wgt, input logic last,
                             input bit typed, input logic [31:0] typed_sum, input bit idling);
        t_sweep_result res;
        i_func <= f;
        i_element_index <= idx;
        i_add_value <= addv;
        i_sub_value <= subv;
        i_out_weight <= wgt;
        i_last <= last;
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        items_sent++;
        if (accumulate_element(f, idx, addv, subv, wgt, last, res)) begin
            if (typed) res.dot_sum = typed_sum;
            sweep_results_due.push_back(res);
        end
        if (idling && $urandom_range(0, 99) < 17) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic set_clamp(input logic [14:0] v);
        start <= 1'b0;
        while (sweep_results_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        i_clamp_we <= 1'b1;
        i_clamp_high <= v;
        @(posedge i_clk);
        i_clamp_we <= 1'b0;
        clamp_image = v;
        clamp_writes++;
    endtask

    task automatic run_sweeps(input int n_items, input bit idling);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 15) begin
                // stray item, last mark at random
                send_item(t_func'($urandom_range(0, 3)), 11'($urandom_range(0, 2047)),
                          16'($urandom), 16'($urandom), $urandom,
                          1'($urandom_range(0, 1)), 1'b0, 32'd0, idling);
                sent++;
            end else begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    send_item(t_func'($urandom_range(0, 3)), pick_index(), pick_value(),
                              pick_value(), pick_weight(), k == len - 1, 1'b0, 32'd0, idling);
                end
                sent += len;
            end
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_sweep_result want;
        if (i_rst_n && o_result_valid !== 1'b0) begin
            results_seen++;
            if (sweep_results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: dot_sum %0d func %0d",
                             $signed(o_dot_sum), o_done_func);
            end else begin
                want = sweep_results_due.pop_front();
                if (o_dot_sum !== want.dot_sum || o_done_func !== want.func) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d mismatch: dot_sum exp %0d got %0d, func exp %0d got %0d",
                                 results_seen, $signed(want.dot_sum), $signed(o_dot_sum),
                                 want.func, o_done_func);
                end
            end
        end
    end

    initial begin
        logic [14:0] clamp_value;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[r]) begin
            send_item(DIRECTED_ROWS[r].func, DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].addv,
                      DIRECTED_ROWS[r].subv, DIRECTED_ROWS[r].wgt, DIRECTED_ROWS[r].last,
                      DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].exp_sum, 1'b1);
        end

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: clamp_value = 15'd32767;
                1: clamp_value = 15'd1;
                2: clamp_value = 15'd0;
                3: clamp_value = 15'($urandom_range(2, 32766));
                4: clamp_value = 15'd600;
                default: clamp_value = CLAMP_RESET;
            endcase
            set_clamp(clamp_value);
            // one phase runs back to back
            run_sweeps(125, p != 2);
        end

        start <= 1'b0;
        while (sweep_results_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        mismatches += sweep_results_due.size();

        $display("sent %0d items (%0d from the table), checked %0d sweep results",
                 items_sent, $size(DIRECTED_ROWS), results_seen);
        $display("clamp written %0d times, zero, one and full scale among them", clamp_writes);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
